// File: sv/gwwb_pkg.sv
// gwwb_pkg: widths, state type and lane control bundle for the gray-world white balance
// used by gwwb_lane and gray_world_white_balance; depends on nothing
package gwwb_pkg;

    localparam int PIX_W     = 8;
    localparam int ACC_W     = 28;
    // divisor 3*sum stays below 2^30
    localparam int DIV_W     = 30;
    // value*total and (q+1)*divisor stay below 2^38
    localparam int NUM_W     = 38;
    localparam int TBL_DEPTH = 256;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    localparam logic [PIX_W-1:0]  PIX_MAX  = {PIX_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_FULL = {ACC_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(TBL_DEPTH - 1);

    localparam logic MODE_STATS = 1'b0;
    localparam logic MODE_APPLY = 1'b1;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_INIT,
        ST_SWEEP
    } t_state;

    // control from the sequencer to each channel lane
    typedef struct packed {
        logic              init;
        logic              run;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [NUM_W-1:0]  num;
    } t_lane_ctl;

endpackage

// File: sv/gwwb_lane.sv
// gwwb_lane: one color channel, gain lookup memory plus its table build counters
// depends on gwwb_pkg
module gwwb_lane (
    input  logic                                i_clk,
    input  gwwb_pkg::t_lane_ctl                 i_ctl,
    input  logic [gwwb_pkg::ACC_W-1:0]          i_sum,
    input  logic                                i_rd_en,
    input  logic [gwwb_pkg::ADDR_W-1:0]         i_rd_addr,
    output logic [gwwb_pkg::PIX_W-1:0]          o_rd_data,
    output logic                                o_adv
);

    logic [gwwb_pkg::PIX_W-1:0] r_mem [gwwb_pkg::TBL_DEPTH];
    logic [gwwb_pkg::PIX_W-1:0] r_rd;
    logic [gwwb_pkg::PIX_W-1:0] r_q;
    logic [gwwb_pkg::NUM_W-1:0] r_b;
    logic [gwwb_pkg::DIV_W-1:0] r_div;
    logic [gwwb_pkg::DIV_W-1:0] n_div;

    // divisor is three times the channel sum
    assign n_div = gwwb_pkg::DIV_W'(i_sum) + (gwwb_pkg::DIV_W'(i_sum) << 1);

    // step the quotient while (q+1)*div still fits under value*total
    assign o_adv = i_ctl.run && (r_div != '0) && (r_q != gwwb_pkg::PIX_MAX)
                   && (r_b <= i_ctl.num);

    // quotient walk
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_div <= n_div;
            r_q   <= '0;
            r_b   <= gwwb_pkg::NUM_W'(n_div);
        end else if (o_adv) begin
            r_q <= r_q + 1'b1;
            r_b <= r_b + gwwb_pkg::NUM_W'(r_div);
        end
    end

    // gain table, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_ctl.addr] <= r_q;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: sv/gray_world_white_balance.sv
// gray_world_white_balance: top level, channel sums, table build sequencer, apply path
// depends on gwwb_pkg and gwwb_lane
//
// channel  handshake                  payload
// in       i_in_valid / o_in_ready    i_mode, i_in_blue, i_in_green, i_in_red, i_frame_end
// out      o_out_valid / i_out_ready  o_out_blue, o_out_green, o_out_red, o_out_last
//
// one pixel per cycle in both passes unless the input is held off; an apply pixel shows at the output
// in the cycle after it is taken, from a per-channel 256-entry gain table read through a registered port.
// the statistics pixel that ends a frame starts a table rebuild with the input held off: a setup
// state, then one table write per sample value, each write held back while some lane still needs
// a quotient step.
// reset clears sums and marks the table empty (all outputs 0).
// a stalled output holds the input off only while its result waits.
module gray_world_white_balance (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic [gwwb_pkg::PIX_W-1:0]   i_in_blue,
    input  logic [gwwb_pkg::PIX_W-1:0]   i_in_green,
    input  logic [gwwb_pkg::PIX_W-1:0]   i_in_red,
    input  logic                         i_frame_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gwwb_pkg::PIX_W-1:0]   o_out_blue,
    output logic [gwwb_pkg::PIX_W-1:0]   o_out_green,
    output logic [gwwb_pkg::PIX_W-1:0]   o_out_red,
    output logic                         o_out_last
);

    gwwb_pkg::t_state r_state, n_state;

    logic [gwwb_pkg::ACC_W-1:0]  r_acc_b, r_acc_g, r_acc_r;
    logic [gwwb_pkg::ACC_W-1:0]  n_acc_b, n_acc_g, n_acc_r;
    logic [gwwb_pkg::ACC_W-1:0]  r_held_b, r_held_g, r_held_r;
    logic [gwwb_pkg::DIV_W-1:0]  r_total;
    logic [gwwb_pkg::NUM_W-1:0]  r_num;
    logic [gwwb_pkg::ADDR_W-1:0] r_v;
    logic                        r_tbl_ok;
    logic                        r_out_valid, r_out_last, r_out_zero;

    logic in_acc, stats_acc, apply_acc, stats_end;
    logic wr, any_adv, adv_b, adv_g, adv_r, sweep_done;
    logic [gwwb_pkg::PIX_W-1:0] rd_b, rd_g, rd_r;
    gwwb_pkg::t_lane_ctl ctl;

    // input transaction decode
    assign o_in_ready = (r_state == gwwb_pkg::ST_RUN) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign stats_acc  = in_acc && (i_mode == gwwb_pkg::MODE_STATS);
    assign apply_acc  = in_acc && (i_mode == gwwb_pkg::MODE_APPLY);
    assign stats_end  = stats_acc && i_frame_end;

    // saturating channel sums
    function automatic logic [gwwb_pkg::ACC_W-1:0] sat_add(
        input logic [gwwb_pkg::ACC_W-1:0] acc,
        input logic [gwwb_pkg::PIX_W-1:0] v
    );
        logic [gwwb_pkg::ACC_W:0] s;
        s = {1'b0, acc} + (gwwb_pkg::ACC_W+1)'(v);
        return s[gwwb_pkg::ACC_W] ? gwwb_pkg::ACC_FULL : s[gwwb_pkg::ACC_W-1:0];
    endfunction

    assign n_acc_b = sat_add(r_acc_b, i_in_blue);
    assign n_acc_g = sat_add(r_acc_g, i_in_green);
    assign n_acc_r = sat_add(r_acc_r, i_in_red);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_b  <= '0;
            r_acc_g  <= '0;
            r_acc_r  <= '0;
            r_held_b <= '0;
            r_held_g <= '0;
            r_held_r <= '0;
        end else if (stats_end) begin
            r_held_b <= n_acc_b;
            r_held_g <= n_acc_g;
            r_held_r <= n_acc_r;
            r_acc_b  <= '0;
            r_acc_g  <= '0;
            r_acc_r  <= '0;
        end else if (stats_acc) begin
            r_acc_b <= n_acc_b;
            r_acc_g <= n_acc_g;
            r_acc_r <= n_acc_r;
        end
    end

    // table build: a lane steps its quotient, or all lanes write the current value
    assign any_adv    = adv_b || adv_g || adv_r;
    assign wr         = (r_state == gwwb_pkg::ST_SWEEP) && !any_adv;
    assign sweep_done = wr && (r_v == gwwb_pkg::ADDR_TOP);

    always_comb begin
        ctl.init = (r_state == gwwb_pkg::ST_INIT);
        ctl.run  = (r_state == gwwb_pkg::ST_SWEEP);
        ctl.wr   = wr;
        ctl.addr = r_v;
        ctl.num  = r_num;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gwwb_pkg::ST_INIT) begin
            r_total <= gwwb_pkg::DIV_W'(r_held_b) + gwwb_pkg::DIV_W'(r_held_g)
                       + gwwb_pkg::DIV_W'(r_held_r);
            r_num   <= '0;
            r_v     <= '0;
        end else if (wr) begin
            r_num <= r_num + gwwb_pkg::NUM_W'(r_total);
            r_v   <= r_v + 1'b1;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gwwb_pkg::ST_RUN;
            r_tbl_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (sweep_done) begin
                r_tbl_ok <= 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gwwb_pkg::ST_RUN: begin
                if (stats_end) begin
                    n_state = gwwb_pkg::ST_INIT;
                end
            end
            gwwb_pkg::ST_INIT: begin
                n_state = gwwb_pkg::ST_SWEEP;
            end
            gwwb_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = gwwb_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = gwwb_pkg::ST_RUN;
            end
        endcase
    end

    // channel lanes
    gwwb_lane u_lane_b (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_sum     (r_held_b),
        .i_rd_en   (apply_acc),
        .i_rd_addr (i_in_blue),
        .o_rd_data (rd_b),
        .o_adv     (adv_b)
    );

    gwwb_lane u_lane_g (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_sum     (r_held_g),
        .i_rd_en   (apply_acc),
        .i_rd_addr (i_in_green),
        .o_rd_data (rd_g),
        .o_adv     (adv_g)
    );

    gwwb_lane u_lane_r (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_sum     (r_held_r),
        .i_rd_en   (apply_acc),
        .i_rd_addr (i_in_red),
        .o_rd_data (rd_r),
        .o_adv     (adv_r)
    );

    // output stage, table read data is the payload register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_acc) begin
            r_out_last <= i_frame_end;
            r_out_zero <= !r_tbl_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_blue  = r_out_zero ? '0 : rd_b;
    assign o_out_green = r_out_zero ? '0 : rd_g;
    assign o_out_red   = r_out_zero ? '0 : rd_r;

`ifndef SYNTH
    // an apply transaction always shows a result in the next cycle
    a_apply_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_acc |=> o_out_valid)
        else $error("apply transaction gave no result");

    // the pixel ending a statistics frame starts a table rebuild
    a_stats_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stats_end |=> (r_state == gwwb_pkg::ST_INIT))
        else $error("frame end did not start the table rebuild");

    // the table becomes valid only at the end of a rebuild
    a_tbl_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_tbl_ok) |-> $past(r_state == gwwb_pkg::ST_SWEEP))
        else $error("table marked valid outside a rebuild");
`endif

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for gray_world_white_balance, directed and random frames
// depends on gwwb_pkg and gray_world_white_balance; predicts every balanced pixel in-house
module tb_top;

    localparam int          RST_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int          RANDOM_PX   = 340;
    localparam int          PRINT_CAP   = 100;
    // length of the bright frame in the closing stretch
    localparam int          BRIGHT_PX   = 48;

    typedef struct packed {
        logic [gwwb_pkg::PIX_W-1:0] blue;
        logic [gwwb_pkg::PIX_W-1:0] green;
        logic [gwwb_pkg::PIX_W-1:0] red;
        logic                       last;
    } t_balanced_px;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic                       i_mode;
    logic [gwwb_pkg::PIX_W-1:0] i_in_blue;
    logic [gwwb_pkg::PIX_W-1:0] i_in_green;
    logic [gwwb_pkg::PIX_W-1:0] i_in_red;
    logic                       i_frame_end;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic [gwwb_pkg::PIX_W-1:0] o_out_blue;
    logic [gwwb_pkg::PIX_W-1:0] o_out_green;
    logic [gwwb_pkg::PIX_W-1:0] o_out_red;
    logic                       o_out_last;

    // running channel sums and the sums latched at the last frame end
    logic [gwwb_pkg::ACC_W-1:0] run_blue, run_green, run_red;
    logic [gwwb_pkg::ACC_W-1:0] gray_blue, gray_green, gray_red;

    t_balanced_px     balanced_q[$];
    t_balanced_px     head_px;
    int               mismatch_cnt;
    int               px_sent;
    int unsigned      cycle_cnt;
    bit               idle_on;

    gray_world_white_balance dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_in_blue   (i_in_blue),
        .i_in_green  (i_in_green),
        .i_in_red    (i_in_red),
        .i_frame_end (i_frame_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_out_last  (o_out_last)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_CAP)
            $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
    endtask

    // saturating channel sum
    function automatic logic [gwwb_pkg::ACC_W-1:0] sum_sat(logic [gwwb_pkg::ACC_W-1:0] acc,
                                                           logic [gwwb_pkg::PIX_W-1:0] v);
        logic [gwwb_pkg::ACC_W:0] s;
        s = {1'b0, acc} + (gwwb_pkg::ACC_W+1)'(v);
        return (s > {1'b0, gwwb_pkg::ACC_FULL}) ? gwwb_pkg::ACC_FULL : s[gwwb_pkg::ACC_W-1:0];
    endfunction

    // gray-world gain on one sample: v * total / (3 * channel sum), capped at full scale, 0 for a zero sum
    function automatic logic [gwwb_pkg::PIX_W-1:0] gain_sample(
        logic [gwwb_pkg::PIX_W-1:0] v,
        logic [gwwb_pkg::ACC_W-1:0] chan_sum,
        logic [gwwb_pkg::ACC_W+1:0] total
    );
        longint unsigned q;
        if (chan_sum == '0)
            return '0;
        q = (64'(v) * 64'(total)) / (64'd3 * 64'(chan_sum));
        return (q > 64'(gwwb_pkg::PIX_MAX)) ? gwwb_pkg::PIX_MAX : q[gwwb_pkg::PIX_W-1:0];
    endfunction

    // update sums for a statistics pixel, or queue the balanced pixel for an apply pixel
    task automatic balance_pixel(input logic mode, input logic [gwwb_pkg::PIX_W-1:0] b, g, r,
                                 input logic last);
        logic [gwwb_pkg::ACC_W+1:0] total;
        t_balanced_px               px;
        if (mode == gwwb_pkg::MODE_STATS) begin
            run_blue  = sum_sat(run_blue, b);
            run_green = sum_sat(run_green, g);
            run_red   = sum_sat(run_red, r);
            if (last) begin
                gray_blue  = run_blue;
                gray_green = run_green;
                gray_red   = run_red;
                run_blue   = '0;
                run_green  = '0;
                run_red    = '0;
            end
        end else begin
            total    = (gwwb_pkg::ACC_W+2)'(gray_blue) + (gwwb_pkg::ACC_W+2)'(gray_green)
                       + (gwwb_pkg::ACC_W+2)'(gray_red);
            px.blue  = gain_sample(b, gray_blue, total);
            px.green = gain_sample(g, gray_green, total);
            px.red   = gain_sample(r, gray_red, total);
            px.last  = last;
            balanced_q = {balanced_q, px};
        end
    endtask

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_pixel(input logic mode, input logic [gwwb_pkg::PIX_W-1:0] b, g, r,
                              input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_in_blue   <= b;
        i_in_green  <= g;
        i_in_red    <= r;
        i_frame_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        px_sent++;
        balance_pixel(mode, b, g, r, last);
    endtask

    // output side: check each transaction against the oldest predicted pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (balanced_q.size() == 0) begin
                report_mismatch("output with nothing expected", 1, 0);
            end else begin
                head_px = balanced_q.pop_front();
                if (o_out_blue !== head_px.blue)
                    report_mismatch("blue", int'(o_out_blue), int'(head_px.blue));
                if (o_out_green !== head_px.green)
                    report_mismatch("green", int'(o_out_green), int'(head_px.green));
                if (o_out_red !== head_px.red)
                    report_mismatch("red", int'(o_out_red), int'(head_px.red));
                if (o_out_last !== head_px.last)
                    report_mismatch("last", int'(o_out_last), int'(head_px.last));
            end
        end
    end

    // output stalls in random bursts while idling is on
    initial begin
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [gwwb_pkg::PIX_W-1:0] near_level(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return gwwb_pkg::PIX_W'(v);
    endfunction

    // apply samples lean toward the extremes now and then
    function automatic logic [gwwb_pkg::PIX_W-1:0] apply_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return gwwb_pkg::PIX_MAX;
            default: return gwwb_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // apply before any frame was measured: all sums zero, all outputs zero
    task automatic test_apply_before_stats();
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'h80, 8'h01, 8'hFE, 1'b0);
    endtask

    // equal sums from a one-pixel frame: gain is exactly one
    task automatic test_unit_gain();
        send_pixel(gwwb_pkg::MODE_STATS, 8'd200, 8'd200, 8'd200, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'h55, 8'hAA, 8'h01, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd0, 8'd255, 8'd128, 1'b1);
    endtask

    // blue sum zero, red sum tiny so its gain saturates
    task automatic test_zero_channel();
        send_pixel(gwwb_pkg::MODE_STATS, 8'd0, 8'd255, 8'd1, 1'b0);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd0, 8'd255, 8'd1, 1'b0);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd0, 8'd255, 8'd1, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd1, 8'd1, 8'd1, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd0, 8'd0, 8'd0, 1'b1);
    endtask

    // frame end in the apply pass only marks the pixel
    task automatic test_apply_frame_end();
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd10, 8'd20, 8'd30, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd10, 8'd20, 8'd30, 1'b0);
    endtask

    // all-black frame, then apply pixels mixed into an open statistics pass
    task automatic test_black_and_mixed();
        send_pixel(gwwb_pkg::MODE_STATS, 8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd255, 8'd128, 8'd7, 1'b1);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd40, 8'd50, 8'd60, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd90, 8'd91, 8'd92, 1'b0);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd1, 8'd2, 8'd3, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd90, 8'd91, 8'd92, 1'b1);
    endtask

    // mostly well-formed frame pairs with random color casts, some noise
    task automatic test_random_frames(input int target);
        int start_cnt, n_px, k;
        int base_b, base_g, base_r, sp_b, sp_g, sp_r;
        start_cnt = px_sent;
        while (px_sent - start_cnt < target) begin
            if ($urandom_range(0, 4) == 0) begin
                n_px = $urandom_range(1, 8);
                for (k = 0; k < n_px; k++)
                    send_pixel(1'($urandom_range(0, 1)),
                               gwwb_pkg::PIX_W'($urandom_range(0, 255)),
                               gwwb_pkg::PIX_W'($urandom_range(0, 255)),
                               gwwb_pkg::PIX_W'($urandom_range(0, 255)),
                               $urandom_range(0, 3) == 0);
            end else begin
                base_b = $urandom_range(0, 255);
                base_g = $urandom_range(0, 255);
                base_r = $urandom_range(0, 255);
                sp_b   = $urandom_range(0, 128);
                sp_g   = $urandom_range(0, 128);
                sp_r   = $urandom_range(0, 128);
                // a dead channel now and then
                case ($urandom_range(0, 11))
                    0: begin base_b = 0; sp_b = 0; end
                    1: begin base_g = 0; sp_g = 0; end
                    2: begin base_r = 0; sp_r = 0; end
                    default: ;
                endcase
                n_px = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
                for (k = 0; k < n_px; k++)
                    send_pixel(gwwb_pkg::MODE_STATS, near_level(base_b, sp_b),
                               near_level(base_g, sp_g), near_level(base_r, sp_r),
                               k == n_px - 1);
                n_px = $urandom_range(1, 16);
                for (k = 0; k < n_px; k++)
                    send_pixel(gwwb_pkg::MODE_APPLY, apply_level(), apply_level(),
                               apply_level(), k == n_px - 1);
            end
        end
    endtask

    // bright frame back to back, then a short frame shows the sums were cleared
    task automatic test_full_rate();
        int k;
        for (k = 0; k < BRIGHT_PX; k++)
            send_pixel(gwwb_pkg::MODE_STATS, 8'd255, 8'd254,
                       gwwb_pkg::PIX_W'($urandom_range(0, 255)), k == BRIGHT_PX - 1);
        for (k = 0; k < 16; k++)
            send_pixel(gwwb_pkg::MODE_APPLY, apply_level(), apply_level(), apply_level(),
                       k == 15);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd30, 8'd60, 8'd90, 1'b0);
        send_pixel(gwwb_pkg::MODE_STATS, 8'd30, 8'd60, 8'd90, 1'b1);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(gwwb_pkg::MODE_APPLY, 8'd100, 8'd100, 8'd100, 1'b1);
    endtask

    // main sequence
    initial begin
        idle_on      = 1'b1;
        mismatch_cnt = 0;
        px_sent      = 0;
        run_blue     = '0;
        run_green    = '0;
        run_red      = '0;
        gray_blue    = '0;
        gray_green   = '0;
        gray_red     = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= gwwb_pkg::MODE_STATS;
        i_in_blue   <= '0;
        i_in_green  <= '0;
        i_in_red    <= '0;
        i_frame_end <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_apply_before_stats();
        test_unit_gain();
        test_zero_channel();
        test_apply_frame_end();
        test_black_and_mixed();
        test_random_frames(RANDOM_PX);
        // closing stretch at full rate
        idle_on = 1'b0;
        test_full_rate();
        i_in_valid <= 1'b0;

        while (balanced_q.size() != 0)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
